### hdl/lpr_pkg.sv
package lpr_pkg;

  localparam int IDX_W  = 5;
  localparam int AGE_W  = 5;
  localparam int PAGE_W = 16;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 4;
  localparam int FIDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 4'd4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef struct packed {
    logic  hit;
    idx_t  hit_idx;
    age_t  hit_age;
    logic  empty;
    idx_t  empty_idx;
    age_t  old_age;
    idx_t  old_idx;
    page_t old_page;
  } search_t;

  typedef struct packed {
    logic en;
    logic write;
    logic clear;
    logic age_all;
    idx_t sel;
    age_t limit;
  } update_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

endpackage

### hdl/lpr_req_if.sv
interface lpr_req_if;
  logic                       valid;
  logic                       ready;
  logic [lpr_pkg::PAGE_W-1:0] page_number;
  logic                       last_reference;

  modport source (output valid, output page_number, output last_reference, input ready);
  modport sink (input valid, input page_number, input last_reference, output ready);
endinterface

### hdl/lpr_rsp_if.sv
interface lpr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lpr_pkg::FIDX_W-1:0] frame_index;
  logic                       evicted_valid;
  logic [lpr_pkg::PAGE_W-1:0] evicted_page;
  logic [lpr_pkg::CNT_W-1:0]  hit_total;
  logic [lpr_pkg::CNT_W-1:0]  miss_total;
  logic                       end_of_string;

  modport source (
    output valid, output hit, output frame_index, output evicted_valid,
    output evicted_page, output hit_total, output miss_total, output end_of_string,
    input ready
  );
  modport sink (
    input valid, input hit, input frame_index, input evicted_valid,
    input evicted_page, input hit_total, input miss_total, input end_of_string,
    output ready
  );
endinterface

### hdl/lpr_cfg_if.sv
interface lpr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lpr_pkg::CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/lpr_cell.sv
module lpr_cell #(
  parameter int FRAMES   = 8,
  parameter int PW       = 16,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [PW-1:0]     req_page,
  input  logic [5:0]        active_n,
  input  lpr_pkg::search_t  srch_in,
  output lpr_pkg::search_t  srch_out,
  input  lpr_pkg::update_t  upd
);

  localparam int AW = $clog2(FRAMES);
  localparam logic [AW-1:0] AGE_MAX = AW'(FRAMES - 1);
  localparam lpr_pkg::idx_t MY_IDX = lpr_pkg::idx_t'(CELL_IDX);

  logic [PW-1:0]    page;
  logic             valid;
  logic [AW-1:0]    age;
  lpr_pkg::age_t    age_ext;
  logic             active;
  logic             selected;
  lpr_pkg::search_t srch_next;

  assign age_ext  = lpr_pkg::age_t'(age);
  assign active   = active_n > 6'(CELL_IDX);
  assign selected = upd.sel == MY_IDX;

  always_comb begin
    srch_next = srch_in;
    if (active && valid && (page == req_page) && !srch_in.hit) begin
      srch_next.hit     = 1'b1;
      srch_next.hit_idx = MY_IDX;
      srch_next.hit_age = age_ext;
    end
    if (active && !valid && !srch_in.empty) begin
      srch_next.empty     = 1'b1;
      srch_next.empty_idx = MY_IDX;
    end
    if (active && ((CELL_IDX == 0) || (age_ext > srch_in.old_age))) begin
      srch_next.old_age  = age_ext;
      srch_next.old_idx  = MY_IDX;
      srch_next.old_page = lpr_pkg::page_t'(page);
    end
  end

  always_ff @(posedge clk) begin
    srch_out <= srch_next;
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.write && selected) begin
      page <= req_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else if (upd.en) begin
      if (selected) begin
        age <= '0;
        if (upd.write) begin
          valid <= 1'b1;
        end
      end else if (valid && (upd.age_all || (age_ext < upd.limit)) && (age != AGE_MAX)) begin
        age <= age + AW'(1);
      end
      if (upd.clear) begin
        valid <= 1'b0;
        age   <= '0;
      end
    end
  end

endmodule

### hdl/lru_page_replacement_core.sv
// An accepted request is registered; its search record then walks the chain of frame
// cells one frame per cycle, and the update state updates all cells at once and writes the
// output register, waiting while an unread result still holds it. One request is handled at a time.
// A new request is accepted while a finished result still waits in the output register.
// Synchronous reset empties all frames, clears ages and totals, and sets frames_in_use to 4.
module lru_page_replacement_core #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  lpr_req_if.sink   req,
  lpr_rsp_if.source rsp,
  lpr_cfg_if.sink   cfg
);

  localparam int PW = (PAGE_BITS < lpr_pkg::PAGE_W) ? PAGE_BITS : lpr_pkg::PAGE_W;
  localparam int CW = $clog2(FRAMES);

  lpr_pkg::state_t state, state_next;
  logic [CW-1:0]   cnt;
  logic [lpr_pkg::CFG_W-1:0] frames_in_use;
  logic [5:0]      active_n;
  logic [PW-1:0]   req_page;
  logic            req_last;
  logic            rsp_valid;
  logic            req_ready_c;
  logic            accept;

  lpr_pkg::search_t rec [FRAMES];
  lpr_pkg::search_t fin;
  lpr_pkg::update_t upd;
  lpr_pkg::idx_t    f;
  logic             ev_valid;
  lpr_pkg::count_t  hit_count, miss_count;
  lpr_pkg::count_t  hit_count_next, miss_count_next;

  assign cfg.ready = !rst;
  assign req.ready = req_ready_c;
  assign accept    = req.valid && req_ready_c;
  assign rsp.valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lpr_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg.valid) begin
      frames_in_use <= cfg.data;
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      active_n = 6'd1;
    end else if ({2'b00, frames_in_use} > 6'(FRAMES)) begin
      active_n = 6'(FRAMES);
    end else begin
      active_n = {2'b00, frames_in_use};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_page <= req.page_number[PW-1:0];
      req_last <= req.last_reference;
    end
  end

  genvar k;
  generate
    for (k = 0; k < FRAMES; k++) begin : g_cell
      lpr_pkg::search_t srch_in;
      if (k == 0) begin : g_head
        assign srch_in = '0;
      end else begin : g_link
        assign srch_in = rec[k-1];
      end
      lpr_cell #(
        .FRAMES   (FRAMES),
        .PW       (PW),
        .CELL_IDX (k)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .req_page (req_page),
        .active_n (active_n),
        .srch_in  (srch_in),
        .srch_out (rec[k]),
        .upd      (upd)
      );
    end
  endgenerate

  assign fin      = rec[FRAMES-1];
  assign ev_valid = !fin.hit && !fin.empty;

  always_comb begin
    if (fin.hit) begin
      f = fin.hit_idx;
    end else if (fin.empty) begin
      f = fin.empty_idx;
    end else begin
      f = fin.old_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready_c = 1'b0;
    upd         = '0;
    upd.write   = !fin.hit;
    upd.clear   = req_last;
    upd.age_all = !fin.hit;
    upd.sel     = f;
    upd.limit   = fin.hit_age;
    case (state)
      lpr_pkg::ST_IDLE: begin
        req_ready_c = !rst;
        if (req.valid) begin
          state_next = lpr_pkg::ST_SEARCH;
        end
      end
      lpr_pkg::ST_SEARCH: begin
        if (cnt == CW'(FRAMES - 1)) begin
          state_next = lpr_pkg::ST_UPDATE;
        end
      end
      lpr_pkg::ST_UPDATE: begin
        if (!rsp_valid || rsp.ready) begin
          upd.en     = 1'b1;
          state_next = lpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == lpr_pkg::ST_SEARCH) begin
      cnt <= cnt + CW'(1);
    end else begin
      cnt <= '0;
    end
  end

  assign hit_count_next = (fin.hit && (hit_count != lpr_pkg::COUNT_MAX))
                          ? hit_count + lpr_pkg::count_t'(1) : hit_count;
  assign miss_count_next = (!fin.hit && (miss_count != lpr_pkg::COUNT_MAX))
                           ? miss_count + lpr_pkg::count_t'(1) : miss_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count  <= '0;
      miss_count <= '0;
    end else if (upd.en) begin
      if (req_last) begin
        hit_count  <= '0;
        miss_count <= '0;
      end else begin
        hit_count  <= hit_count_next;
        miss_count <= miss_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (upd.en) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      rsp.hit           <= fin.hit;
      rsp.frame_index   <= f[lpr_pkg::FIDX_W-1:0];
      rsp.evicted_valid <= ev_valid;
      rsp.evicted_page  <= ev_valid ? fin.old_page : '0;
      rsp.hit_total     <= hit_count_next;
      rsp.miss_total    <= miss_count_next;
      rsp.end_of_string <= req_last;
    end
  end

endmodule
